// ===== design/assert_macros.svh =====
// Assertion macros for the RTL of the GF(2^m) ALU.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication under reset.
`define ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication under reset.
`define ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(label, ck, rn, ante, cons)
`define ASSERT_NXT(label, ck, rn, ante, cons)
`endif
`endif

// ===== design/gfa_pkg.sv =====
// Types and constants of the GF(2^m) ALU.
package gfa_pkg;

    localparam int SYM_W      = 8;
    localparam int MAX_BITS   = 8;
    localparam int MIN_BITS   = 2;
    localparam int M_W        = 4;
    localparam int POLY_W     = SYM_W + 1;
    localparam int KIND_W     = 3;
    localparam int ERR_W      = 2;
    localparam int TAB_AW     = SYM_W;
    localparam int TAB_DEPTH  = 1 << TAB_AW;

    // exponent before reduction: widest is log * exponent
    localparam int PROD_W     = 2 * SYM_W;
    // modulus is at least 3, so the quotient fits in PROD_W-1 bits
    localparam int RED_STEPS  = PROD_W - 1;
    localparam int RED_STAGES = 3;
    localparam int RED_PER_ST = (RED_STEPS + RED_STAGES - 1) / RED_STAGES;
    localparam int CMP_W      = SYM_W + RED_STEPS;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = POLY_W;

    localparam logic [M_W-1:0]    FIELD_BITS_RST = M_W'(8);
    localparam logic [POLY_W-1:0] FIELD_POLY_RST = POLY_W'(285);

    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_BITS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_POLY = CFG_IDX_W'(1);

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD  = 3'd0,
        KIND_SUB  = 3'd1,
        KIND_MULT = 3'd2,
        KIND_DIV  = 3'd3,
        KIND_POW  = 3'd4,
        KIND_INV  = 3'd5,
        KIND_SQRT = 3'd6
    } kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_ZERO  = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        RB_CLEAR,
        RB_BUILD,
        RB_READY
    } rb_state_t;

    // item as captured at the input
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SYM_W-1:0]  a;
        logic [SYM_W-1:0]  b;
    } in_item_t;

    // item in flight after decode
    typedef struct packed {
        err_t              err;
        logic              direct;   // result is dval, no antilog lookup
        logic [SYM_W-1:0]  dval;
        logic [PROD_W-1:0] x;        // exponent, reduced mod n along the way
    } op_item_t;

endpackage

// ===== design/gfa_ram.sv =====
// Generic single-write, single-read RAM with registered read.
module gfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/gf2m_field_alu_core.sv =====
// Top level of the GF(2^m) arithmetic unit: table builder and item pipeline.
//
// GF(2^m) ALU, m = 2..8 with a programmable generating polynomial. Each item
// carries an operation (add, sub, mult, div, pow, inv, sqrt) and two operands
// and yields one item with a field element and an error code (1: operand
// out of range or unknown operation, 2: division or inversion of zero; the
// result is then 0). Throughput is one item per clock while out_stall is
// low and no table rebuild runs. The pipeline has six stages: input capture
// with the two log reads, decode and the log-times-exponent multiply, three
// stages of modulo-(2^m-1) reduction (five compare-subtract steps each), and
// the antilog read into the output stage. A stalled output stage holds its
// item; earlier stages keep filling bubbles, so items are still taken while
// a result waits, until the pipeline is full. After reset and after every
// configuration write the log and antilog tables are rebuilt: all 256 log
// entries are cleared, then the 2^m-1 powers of alpha are walked; in_stall
// stays high until the rebuild ends. Configuration writes are taken at any
// time and restart the rebuild; m below 2 acts as 2 and above 8 as 8.
`include "assert_macros.svh"

module gf2m_field_alu_core (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_write,
    input  logic [gfa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gfa_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [gfa_pkg::KIND_W-1:0]      kind,
    input  logic [gfa_pkg::SYM_W-1:0]       operand_a,
    input  logic [gfa_pkg::SYM_W-1:0]       operand_b,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [gfa_pkg::SYM_W-1:0]       result,
    output logic [gfa_pkg::ERR_W-1:0]       error
);

    import gfa_pkg::*;

    // stage 0 is decode, 1..RED_STAGES reduction, LAST the output stage
    localparam int LAST = RED_STAGES + 1;

    // ---------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------
    logic [M_W-1:0]    field_bits_reg;
    logic [POLY_W-1:0] field_poly_reg;
    logic [M_W-1:0]    m_eff;
    logic [SYM_W-1:0]  mask;   // also the modulus n = 2^m - 1

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_bits_reg <= FIELD_BITS_RST;
            field_poly_reg <= FIELD_POLY_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FIELD_BITS: field_bits_reg <= cfg_data[M_W-1:0];
                CFG_FIELD_POLY: field_poly_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (field_bits_reg < M_W'(MIN_BITS))
        begin
            m_eff = M_W'(MIN_BITS);
        end
        else if (field_bits_reg > M_W'(MAX_BITS))
        begin
            m_eff = M_W'(MAX_BITS);
        end
        else
        begin
            m_eff = field_bits_reg;
        end
        mask = SYM_W'((POLY_W'(1) << m_eff) - POLY_W'(1));
    end

    // ---------------------------------------------------------------
    // table rebuild sequencer
    // ---------------------------------------------------------------
    rb_state_t         rb_state_reg, rb_state_next;
    logic [TAB_AW-1:0] rb_cnt_reg, rb_cnt_next;
    logic [SYM_W-1:0]  rb_val_reg, rb_val_next;
    logic [POLY_W-1:0] rb_shift;

    logic              log_we;
    logic [TAB_AW-1:0] log_waddr;
    logic [SYM_W-1:0]  log_wdata;
    logic              alog_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rb_state_reg <= RB_CLEAR;
            rb_cnt_reg   <= '0;
            rb_val_reg   <= SYM_W'(1);
        end
        else
        begin
            rb_state_reg <= rb_state_next;
            rb_cnt_reg   <= rb_cnt_next;
            rb_val_reg   <= rb_val_next;
        end
    end

    always_comb
    begin
        rb_state_next = rb_state_reg;
        rb_cnt_next   = rb_cnt_reg;
        rb_val_next   = rb_val_reg;
        log_we        = 1'b0;
        log_waddr     = rb_cnt_reg;
        log_wdata     = '0;
        alog_we       = 1'b0;

        // next power of alpha: shift, fold in the polynomial, keep m bits
        rb_shift = {rb_val_reg, 1'b0};
        if (rb_shift[m_eff])
        begin
            rb_shift = rb_shift ^ field_poly_reg;
        end

        unique case (rb_state_reg)
            RB_CLEAR:
            begin
                log_we      = 1'b1;
                rb_cnt_next = rb_cnt_reg + TAB_AW'(1);
                if (rb_cnt_reg == TAB_AW'(TAB_DEPTH - 1))
                begin
                    rb_state_next = RB_BUILD;
                    rb_cnt_next   = '0;
                    rb_val_next   = SYM_W'(1);
                end
            end
            RB_BUILD:
            begin
                log_we      = 1'b1;
                log_waddr   = rb_val_reg;
                log_wdata   = rb_cnt_reg;
                alog_we     = 1'b1;
                rb_cnt_next = rb_cnt_reg + TAB_AW'(1);
                rb_val_next = rb_shift[SYM_W-1:0] & mask;
                if (rb_cnt_reg == mask - SYM_W'(1))
                begin
                    rb_state_next = RB_READY;
                end
            end
            RB_READY:
            begin
            end
            default:
            begin
                rb_state_next = RB_CLEAR;
            end
        endcase

        // any write restarts the rebuild
        if (cfg_write)
        begin
            rb_state_next = RB_CLEAR;
            rb_cnt_next   = '0;
        end
    end

    // ---------------------------------------------------------------
    // pipeline control: a stage moves when empty or its successor moves
    // ---------------------------------------------------------------
    logic     a_valid_reg;
    in_item_t a_item_reg;
    logic     adv_a;
    logic     valid_reg [LAST+1];
    op_item_t pipe_reg  [LAST+1];
    logic     adv       [LAST+1];
    logic     accept;

    always_comb
    begin
        adv[LAST] = !valid_reg[LAST] || !out_stall;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        adv_a = !a_valid_reg || adv[0];
    end

    assign in_stall = !adv_a || (rb_state_reg != RB_READY);
    assign accept   = in_valid && !in_stall;

    // ---------------------------------------------------------------
    // tables; the log table is kept twice for the two operand lookups
    // ---------------------------------------------------------------
    logic [SYM_W-1:0] log_a_q, log_b_q, alog_q;

    gfa_ram #(.WIDTH(SYM_W), .DEPTH(TAB_DEPTH)) u_log_a (
        .clk     (clk),
        .wr_en   (log_we),
        .wr_addr (log_waddr),
        .wr_data (log_wdata),
        .rd_en   (adv_a),
        .rd_addr (operand_a),
        .rd_data (log_a_q)
    );

    gfa_ram #(.WIDTH(SYM_W), .DEPTH(TAB_DEPTH)) u_log_b (
        .clk     (clk),
        .wr_en   (log_we),
        .wr_addr (log_waddr),
        .wr_data (log_wdata),
        .rd_en   (adv_a),
        .rd_addr (operand_b),
        .rd_data (log_b_q)
    );

    gfa_ram #(.WIDTH(SYM_W), .DEPTH(TAB_DEPTH)) u_alog (
        .clk     (clk),
        .wr_en   (alog_we),
        .wr_addr (rb_cnt_reg),
        .wr_data (rb_val_reg),
        .rd_en   (adv[LAST]),
        .rd_addr (pipe_reg[RED_STAGES].x[TAB_AW-1:0]),
        .rd_data (alog_q)
    );

    // ---------------------------------------------------------------
    // input capture
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv_a)
        begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            a_item_reg <= '{kind: kind, a: operand_a, b: operand_b};
        end
    end

    // ---------------------------------------------------------------
    // decode: checks, special cases and the unreduced exponent
    // ---------------------------------------------------------------
    op_item_t          dec_next;
    logic              bad_a, bad_b, a_zero, b_zero;
    logic [PROD_W-1:0] la_w, lb_w, n_w, prod;

    always_comb
    begin
        bad_a  = (a_item_reg.a & ~mask) != '0;
        bad_b  = (a_item_reg.b & ~mask) != '0;
        a_zero = a_item_reg.a == '0;
        b_zero = a_item_reg.b == '0;
        la_w   = PROD_W'(log_a_q);
        lb_w   = PROD_W'(log_b_q);
        n_w    = PROD_W'(mask);
        prod   = la_w * PROD_W'(a_item_reg.b);

        dec_next.err    = ERR_OK;
        dec_next.direct = 1'b1;
        dec_next.dval   = '0;
        dec_next.x      = '0;

        unique case (kind_t'(a_item_reg.kind)) inside
            KIND_ADD, KIND_SUB:
            begin
                if (bad_a || bad_b)
                    dec_next.err = ERR_RANGE;
                else
                    dec_next.dval = a_item_reg.a ^ a_item_reg.b;
            end
            KIND_MULT:
            begin
                if (bad_a || bad_b)
                    dec_next.err = ERR_RANGE;
                else if (!a_zero && !b_zero)
                begin
                    dec_next.direct = 1'b0;
                    dec_next.x      = la_w + lb_w;
                end
            end
            KIND_DIV:
            begin
                if (bad_a || bad_b)
                    dec_next.err = ERR_RANGE;
                else if (b_zero)
                    dec_next.err = ERR_ZERO;
                else if (!a_zero)
                begin
                    dec_next.direct = 1'b0;
                    dec_next.x      = la_w + n_w - lb_w;
                end
            end
            KIND_POW:
            begin
                if (bad_a)
                    dec_next.err = ERR_RANGE;
                else if (b_zero)
                    dec_next.dval = SYM_W'(1);    // x^0, also 0^0
                else if (!a_zero)
                begin
                    dec_next.direct = 1'b0;
                    dec_next.x      = prod;
                end
            end
            KIND_INV:
            begin
                if (bad_a)
                    dec_next.err = ERR_RANGE;
                else if (a_zero)
                    dec_next.err = ERR_ZERO;
                else
                begin
                    dec_next.direct = 1'b0;
                    dec_next.x      = n_w - la_w;
                end
            end
            KIND_SQRT:
            begin
                if (bad_a)
                    dec_next.err = ERR_RANGE;
                else if (!a_zero)
                begin
                    // odd log: (l + n) / 2, even log: l / 2
                    dec_next.direct = 1'b0;
                    dec_next.x      = (la_w + (log_a_q[0] ? n_w : '0)) >> 1;
                end
            end
            default:
            begin
                dec_next.err = ERR_RANGE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // restoring reduction mod n, RED_PER_ST steps per stage
    // ---------------------------------------------------------------
    logic [PROD_W-1:0] red_x [RED_STAGES];

    always_comb
    begin
        logic [CMP_W-1:0] t;
        int               k;
        for (int r = 0; r < RED_STAGES; r++)
        begin
            t = CMP_W'(pipe_reg[r].x);
            for (int j = 0; j < RED_PER_ST; j++)
            begin
                k = RED_STEPS - 1 - (r * RED_PER_ST + j);
                if (k >= 0)
                begin
                    if (t >= (CMP_W'(mask) << k))
                    begin
                        t = t - (CMP_W'(mask) << k);
                    end
                end
            end
            red_x[r] = t[PROD_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // pipeline registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAST; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= a_valid_reg;
            end
            for (int i = 1; i <= LAST; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            pipe_reg[0] <= dec_next;
        end
        for (int r = 0; r < RED_STAGES; r++)
        begin
            if (adv[r+1])
            begin
                pipe_reg[r+1] <= '{err: pipe_reg[r].err, direct: pipe_reg[r].direct,
                                   dval: pipe_reg[r].dval, x: red_x[r]};
            end
        end
        if (adv[LAST])
        begin
            pipe_reg[LAST] <= pipe_reg[RED_STAGES];
        end
    end

    // ---------------------------------------------------------------
    // output stage: antilog data, decoded value, or 0 on an error
    // ---------------------------------------------------------------
    assign out_valid = valid_reg[LAST];
    assign error     = pipe_reg[LAST].err;
    assign result    = (pipe_reg[LAST].err != ERR_OK) ? '0 :
                       pipe_reg[LAST].direct ? pipe_reg[LAST].dval : alog_q;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    logic red_live;    // last reduction stage holds an exponent to look up

    assign red_live = valid_reg[RED_STAGES] && !pipe_reg[RED_STAGES].direct &&
                      (pipe_reg[RED_STAGES].err == ERR_OK);

    `ASSERT_NXT(a_cfg_blocks_input, clk, rst_n, cfg_write, in_stall)
    `ASSERT_IMP(a_reduced_below_n, clk, rst_n, red_live, pipe_reg[RED_STAGES].x < PROD_W'(mask))
    `ASSERT_IMP(a_error_zero_result, clk, rst_n, out_valid && (error != ERR_OK), result == '0)

endmodule
